// ===== sv/sliding_window_history_buffer_macros.svh =====
// Assertion macros shared by the checker of the history buffer.
`ifndef SLIDING_WINDOW_HISTORY_BUFFER_MACROS_SVH
`define SLIDING_WINDOW_HISTORY_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWHB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWHB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/swhb_pkg.sv =====
package swhb_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W = 7;
   localparam int OFF_W = 15;
   localparam int FILL_W = 15;

   localparam int DEF_WINDOW_DEPTH = 32768;
   localparam int DEF_MAX_COPY = 64;

   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int OQ_DEPTH = 4;
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef enum logic [1:0] {
      FN_PUSH  = 2'd0,
      FN_POP   = 2'd1,
      FN_COPY  = 2'd2,
      FN_CLEAR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_POP_EMPTY = 2'd1,
      ST_COPY_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_COPY = 1'b1
   } back_state_type;

   typedef struct packed {
      func_type            func;
      logic [DATA_W-1:0]   data_in;
      logic [LEN_W-1:0]    copy_length;
      logic [OFF_W-1:0]    copy_offset;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   data_out;
      logic                last;
      status_type          status;
      logic [FILL_W-1:0]   fill_count;
      logic                is_empty;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [DATA_W-1:0]   data;
      logic [LEN_W-1:0]    count;
      status_type          status;
      logic [FILL_W-1:0]   fill;
      logic                empty;
   } cmd_type;

endpackage

// ===== sv/swhb_ram.sv =====
module swhb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/swhb_queue.sv =====
module swhb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full = (count_ff == CNT_W'(DEPTH));
      empty = (count_ff == '0);
      do_push = push && !full;
      do_pop = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// ===== sv/swhb_front.sv =====
module swhb_front #(
   parameter int WINDOW_DEPTH = swhb_pkg::DEF_WINDOW_DEPTH,
   parameter int MAX_COPY = swhb_pkg::DEF_MAX_COPY
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  swhb_pkg::req_type               req_data,
   input  logic                            cq_full,
   output logic                            cq_push,
   output logic [$clog2(WINDOW_DEPTH)-1:0] cq_addr,
   output swhb_pkg::cmd_type               cq_cmd
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CW = (PTR_W > swhb_pkg::FILL_W) ? PTR_W : swhb_pkg::FILL_W;
   localparam int XW = CW + 1;
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW_DEPTH - 1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] fill_ff, fill_in;
   logic             accept;
   logic             copy_bad;
   logic [XW-1:0]    fill_x, off_x, len_x, tail_x, start_x;
   logic [CW-1:0]    fill_wide;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      wrap_next = (p == LAST_IDX) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      accept = req_push && !cq_full;
      fill_x = XW'(fill_ff);
      off_x = XW'(req_data.copy_offset);
      len_x = XW'(req_data.copy_length);
      tail_x = XW'(tail_ff);
      copy_bad = (req_data.copy_length == '0)
         || (req_data.copy_length > swhb_pkg::LEN_W'(MAX_COPY))
         || (len_x > off_x) || (off_x > fill_x);
      start_x = (tail_x >= off_x) ? tail_x - off_x : tail_x + XW'(WINDOW_DEPTH) - off_x;

      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      cq_addr = tail_ff;
      cq_cmd.kind = swhb_pkg::CMD_NONE;
      cq_cmd.data = req_data.data_in;
      cq_cmd.count = req_data.copy_length;
      cq_cmd.status = swhb_pkg::ST_OK;

      case (req_data.func)
         swhb_pkg::FN_PUSH: begin
            cq_cmd.kind = swhb_pkg::CMD_WRITE;
            tail_in = wrap_next(tail_ff);
            if (fill_ff == LAST_IDX) begin
               head_in = wrap_next(head_ff);
            end else begin
               fill_in = fill_ff + PTR_W'(1);
            end
         end
         swhb_pkg::FN_POP: begin
            if (fill_ff == '0) begin
               cq_cmd.status = swhb_pkg::ST_POP_EMPTY;
            end else begin
               cq_cmd.kind = swhb_pkg::CMD_READ;
               cq_cmd.count = swhb_pkg::LEN_W'(1);
               cq_addr = head_ff;
               head_in = wrap_next(head_ff);
               fill_in = fill_ff - PTR_W'(1);
            end
         end
         swhb_pkg::FN_COPY: begin
            if (copy_bad) begin
               cq_cmd.status = swhb_pkg::ST_COPY_BAD;
            end else begin
               cq_cmd.kind = swhb_pkg::CMD_READ;
               cq_addr = start_x[PTR_W-1:0];
            end
         end
         swhb_pkg::FN_CLEAR: begin
            head_in = '0;
            tail_in = '0;
            fill_in = '0;
         end
         default: begin
            cq_cmd.kind = swhb_pkg::CMD_NONE;
         end
      endcase

      fill_wide = CW'(fill_in);
      cq_cmd.fill = fill_wide[swhb_pkg::FILL_W-1:0];
      cq_cmd.empty = (fill_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   assign req_full = cq_full;
   assign cq_push = accept;

endmodule

// ===== sv/swhb_back.sv =====
module swhb_back #(
   parameter int WINDOW_DEPTH = swhb_pkg::DEF_WINDOW_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cq_empty,
   output logic                            cq_pop,
   input  logic [$clog2(WINDOW_DEPTH)-1:0] cq_addr,
   input  swhb_pkg::cmd_type               cq_cmd,
   output logic                            ram_wr_en,
   output logic [$clog2(WINDOW_DEPTH)-1:0] ram_wr_addr,
   output logic [swhb_pkg::DATA_W-1:0]     ram_wr_data,
   output logic                            ram_rd_en,
   output logic [$clog2(WINDOW_DEPTH)-1:0] ram_rd_addr,
   input  logic [swhb_pkg::DATA_W-1:0]     ram_rd_data,
   input  logic [swhb_pkg::OQ_CNT_W-1:0]   oq_count,
   output logic                            oq_push,
   output swhb_pkg::rsp_type               oq_data
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int SW = swhb_pkg::OQ_CNT_W + 1;
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW_DEPTH - 1);

   swhb_pkg::back_state_type    state_ff, state_in;
   logic [PTR_W-1:0]            addr_ff, addr_in;
   logic [swhb_pkg::LEN_W-1:0]  remain_ff, remain_in;
   swhb_pkg::cmd_type           meta_ff, meta_in;
   logic                        s2_valid_ff, s2_valid_in;
   logic                        s2_read_ff, s2_read_in;
   swhb_pkg::rsp_type           s2_rsp_ff, s2_rsp_in;
   logic                        space;
   logic                        multi;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      wrap_next = (p == LAST_IDX) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      space = (SW'(oq_count) + SW'(s2_valid_ff)) < SW'(swhb_pkg::OQ_DEPTH);
      multi = (cq_cmd.kind == swhb_pkg::CMD_READ) && (cq_cmd.count > swhb_pkg::LEN_W'(1));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swhb_pkg::BK_IDLE: begin
            if (space && !cq_empty && multi) begin
               state_in = swhb_pkg::BK_COPY;
            end
         end
         swhb_pkg::BK_COPY: begin
            if (space && remain_ff == swhb_pkg::LEN_W'(1)) begin
               state_in = swhb_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = swhb_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cq_pop = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = cq_addr;
      ram_wr_data = cq_cmd.data;
      ram_rd_en = 1'b0;
      ram_rd_addr = addr_ff;
      addr_in = addr_ff;
      remain_in = remain_ff;
      meta_in = meta_ff;
      s2_valid_in = 1'b0;
      s2_read_in = 1'b0;
      s2_rsp_in.data_out = '0;
      s2_rsp_in.last = 1'b1;
      s2_rsp_in.status = cq_cmd.status;
      s2_rsp_in.fill_count = cq_cmd.fill;
      s2_rsp_in.is_empty = cq_cmd.empty;
      case (state_ff)
         swhb_pkg::BK_IDLE: begin
            if (space && !cq_empty) begin
               cq_pop = 1'b1;
               s2_valid_in = 1'b1;
               s2_rsp_in.last = !multi;
               case (cq_cmd.kind)
                  swhb_pkg::CMD_WRITE: begin
                     ram_wr_en = 1'b1;
                  end
                  swhb_pkg::CMD_READ: begin
                     ram_rd_en = 1'b1;
                     ram_rd_addr = cq_addr;
                     s2_read_in = 1'b1;
                     addr_in = wrap_next(cq_addr);
                     remain_in = cq_cmd.count - swhb_pkg::LEN_W'(1);
                     meta_in = cq_cmd;
                  end
                  default: begin
                     s2_read_in = 1'b0;
                  end
               endcase
            end
         end
         swhb_pkg::BK_COPY: begin
            s2_rsp_in.status = meta_ff.status;
            s2_rsp_in.fill_count = meta_ff.fill;
            s2_rsp_in.is_empty = meta_ff.empty;
            if (space) begin
               ram_rd_en = 1'b1;
               s2_valid_in = 1'b1;
               s2_read_in = 1'b1;
               s2_rsp_in.last = (remain_ff == swhb_pkg::LEN_W'(1));
               addr_in = wrap_next(addr_ff);
               remain_in = remain_ff - swhb_pkg::LEN_W'(1);
            end
         end
         default: begin
            s2_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swhb_pkg::BK_IDLE;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      remain_ff <= remain_in;
      meta_ff <= meta_in;
      s2_read_ff <= s2_read_in;
      s2_rsp_ff <= s2_rsp_in;
   end

   always_comb begin
      oq_push = s2_valid_ff;
      oq_data = s2_rsp_ff;
      oq_data.data_out = s2_read_ff ? ram_rd_data : '0;
   end

endmodule

// ===== sv/sliding_window_history_buffer.sv =====
// Byte history window of a compressor, kept as a ring in one RAM of WINDOW_DEPTH bytes
// that holds at most WINDOW_DEPTH minus one bytes. Push, pop and clear each give one
// result beat, and so does a pop from an empty window or a copy whose range is invalid;
// such items are taken one per cycle while the result queue has room; a valid copy of
// length L gives L beats, one per cycle while there is room, as each copied byte is one
// read of the window RAM's single read port. Each beat is registered, then queued. No
// clearing pass runs after reset: the window is empty; only written bytes are read.
module sliding_window_history_buffer #(
   parameter int WINDOW_DEPTH = swhb_pkg::DEF_WINDOW_DEPTH,
   parameter int MAX_COPY = swhb_pkg::DEF_MAX_COPY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  swhb_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output swhb_pkg::rsp_type rsp_data
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CMD_W = $bits(swhb_pkg::cmd_type);
   localparam int CQ_W = PTR_W + CMD_W;

   logic                            cq_push, cq_pop, cq_full, cq_empty;
   logic [PTR_W-1:0]                cq_wr_addr;
   swhb_pkg::cmd_type               cq_wr_cmd;
   logic [CQ_W-1:0]                 cq_rd_data;
   logic [PTR_W-1:0]                cq_rd_addr;
   swhb_pkg::cmd_type               cq_rd_cmd;
   logic                            ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0]                ram_wr_addr, ram_rd_addr;
   logic [swhb_pkg::DATA_W-1:0]     ram_wr_data, ram_rd_data;
   logic [swhb_pkg::OQ_CNT_W-1:0]   oq_count;
   logic                            oq_push, oq_full;
   swhb_pkg::rsp_type               oq_data;

   swhb_front #(
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .MAX_COPY(MAX_COPY)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .cq_full(cq_full),
      .cq_push(cq_push),
      .cq_addr(cq_wr_addr),
      .cq_cmd(cq_wr_cmd)
   );

   swhb_queue #(
      .WIDTH(CQ_W),
      .DEPTH(swhb_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(cq_push),
      .wr_data({cq_wr_addr, cq_wr_cmd}),
      .pop(cq_pop),
      .rd_data(cq_rd_data),
      .full(cq_full),
      .empty(cq_empty),
      .count()
   );

   assign cq_rd_addr = cq_rd_data[CQ_W-1:CMD_W];
   assign cq_rd_cmd = swhb_pkg::cmd_type'(cq_rd_data[CMD_W-1:0]);

   swhb_back #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cq_empty(cq_empty),
      .cq_pop(cq_pop),
      .cq_addr(cq_rd_addr),
      .cq_cmd(cq_rd_cmd),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en(ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .oq_count(oq_count),
      .oq_push(oq_push),
      .oq_data(oq_data)
   );

   swhb_ram #(
      .WIDTH(swhb_pkg::DATA_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_window_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   swhb_queue #(
      .WIDTH($bits(swhb_pkg::rsp_type)),
      .DEPTH(swhb_pkg::OQ_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(oq_push),
      .wr_data(oq_data),
      .pop(rsp_pop),
      .rd_data(rsp_data),
      .full(oq_full),
      .empty(rsp_empty),
      .count(oq_count)
   );

   // The back end reserves queue space before it issues a beat, so no beat is pushed while
   // the queue is full.
   logic unused_oq_full;
   assign unused_oq_full = oq_full;

endmodule

// ===== sv/swhb_checker.sv =====
`include "sliding_window_history_buffer_macros.svh"

module swhb_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input swhb_pkg::rsp_type rsp_data
);

   logic rsp_beat_waits;
   logic rsp_bad;

   assign rsp_beat_waits = !rsp_empty && !rsp_pop;
   assign rsp_bad = !rsp_empty && (rsp_data.status != swhb_pkg::ST_OK);

   `SWHB_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_beat_waits,
      !rsp_empty && $stable(rsp_data), "A stalled result beat changed or vanished.")
   `SWHB_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), rsp_empty,
      "A result beat is shown right after reset.")
   `SWHB_ASSERT_SAME(a_error_single, clock, reset, rsp_bad,
      rsp_data.last && rsp_data.data_out == '0, "An error beat is not a lone zero beat.")
   `SWHB_ASSERT_SAME(a_pop_empty_fill, clock, reset,
      !rsp_empty && rsp_data.status == swhb_pkg::ST_POP_EMPTY,
      rsp_data.is_empty && rsp_data.fill_count == '0, "A pop error beat shows a filled window.")
   `SWHB_ASSERT_SAME(a_empty_flag, clock, reset, !rsp_empty && rsp_data.is_empty,
      rsp_data.fill_count == '0, "The empty flag disagrees with the fill count.")

endmodule

bind sliding_window_history_buffer swhb_checker u_swhb_checker (
   .clock(clock),
   .reset(reset),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_data(rsp_data)
);

// ===== dv/sliding_window_history_buffer_tb.sv =====
module sliding_window_history_buffer_tb;

   localparam int WINDOW_DEPTH = swhb_pkg::DEF_WINDOW_DEPTH;
   localparam int MAX_COPY = swhb_pkg::DEF_MAX_COPY;
   localparam int RANDOM_OPS = 500;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      swhb_pkg::req_type op;
      bit                typed;
      swhb_pkg::rsp_type beat;
   } step_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   swhb_pkg::req_type req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   swhb_pkg::rsp_type rsp_data;

   logic [swhb_pkg::DATA_W-1:0] hist_mem [WINDOW_DEPTH];
   int unsigned oldest_idx = 0;
   int unsigned next_idx = 0;
   swhb_pkg::rsp_type op_beats[$];
   swhb_pkg::rsp_type pending_beats[$];
   step_row_type directed_steps[$];

   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned rx_cycles = 0;
   int unsigned rx_hold = 0;
   bit sender_quiet = 1'b0;

   sliding_window_history_buffer uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned wrap_idx(input int unsigned p);
      return (p + 1) % WINDOW_DEPTH;
   endfunction

   function automatic int unsigned window_fill();
      return (next_idx + WINDOW_DEPTH - oldest_idx) % WINDOW_DEPTH;
   endfunction

   function automatic void add_beat(input logic [swhb_pkg::DATA_W-1:0] d, input bit fin,
                                    input swhb_pkg::status_type st);
      swhb_pkg::rsp_type b;
      b.data_out = d;
      b.last = fin;
      b.status = st;
      b.fill_count = swhb_pkg::FILL_W'(window_fill());
      b.is_empty = (window_fill() == 0);
      op_beats.push_back(b);
   endfunction

   function automatic void predict_window_op(input swhb_pkg::req_type op);
      int unsigned len;
      int unsigned off;
      int unsigned pos;
      op_beats.delete();
      len = op.copy_length;
      off = op.copy_offset;
      case (op.func)
         swhb_pkg::FN_PUSH: begin
            hist_mem[next_idx] = op.data_in;
            next_idx = wrap_idx(next_idx);
            if (next_idx == oldest_idx) oldest_idx = wrap_idx(oldest_idx);
            add_beat('0, 1'b1, swhb_pkg::ST_OK);
         end
         swhb_pkg::FN_POP: begin
            if (oldest_idx == next_idx) begin
               add_beat('0, 1'b1, swhb_pkg::ST_POP_EMPTY);
            end else begin
               pos = oldest_idx;
               oldest_idx = wrap_idx(oldest_idx);
               add_beat(hist_mem[pos], 1'b1, swhb_pkg::ST_OK);
            end
         end
         swhb_pkg::FN_COPY: begin
            if (len == 0 || len > MAX_COPY || len > off || off > window_fill()) begin
               add_beat('0, 1'b1, swhb_pkg::ST_COPY_BAD);
            end else begin
               pos = (next_idx + WINDOW_DEPTH - off) % WINDOW_DEPTH;
               for (int unsigned k = 0; k < len; k++) begin
                  add_beat(hist_mem[pos], k + 1 == len, swhb_pkg::ST_OK);
                  pos = wrap_idx(pos);
               end
            end
         end
         default: begin
            oldest_idx = 0;
            next_idx = 0;
            add_beat('0, 1'b1, swhb_pkg::ST_OK);
         end
      endcase
   endfunction

   function automatic swhb_pkg::req_type mk_req(input swhb_pkg::func_type f,
                                                input int unsigned d,
                                                input int unsigned len,
                                                input int unsigned off);
      swhb_pkg::req_type r;
      r.func = f;
      r.data_in = swhb_pkg::DATA_W'(d);
      r.copy_length = swhb_pkg::LEN_W'(len);
      r.copy_offset = swhb_pkg::OFF_W'(off);
      return r;
   endfunction

   function automatic swhb_pkg::rsp_type mk_beat(input int unsigned d,
                                                 input swhb_pkg::status_type st,
                                                 input int unsigned fill);
      swhb_pkg::rsp_type b;
      b.data_out = swhb_pkg::DATA_W'(d);
      b.last = 1'b1;
      b.status = st;
      b.fill_count = swhb_pkg::FILL_W'(fill);
      b.is_empty = (fill == 0);
      return b;
   endfunction

   function automatic void add_row(input swhb_pkg::req_type op, input bit typed,
                                   input swhb_pkg::rsp_type beat);
      step_row_type s;
      s.op = op;
      s.typed = typed;
      s.beat = beat;
      directed_steps.push_back(s);
   endfunction

   function automatic swhb_pkg::req_type random_window_op();
      int unsigned pick;
      int unsigned fill;
      int unsigned off;
      int unsigned len;
      swhb_pkg::req_type op;
      fill = window_fill();
      op = mk_req(swhb_pkg::FN_PUSH, $urandom_range(0, 255), $urandom_range(0, 127),
                  $urandom_range(0, 32767));
      pick = $urandom_range(0, 99);
      if (pick < 40 || (pick >= 55 && pick < 85 && fill == 0)) begin
         op.func = swhb_pkg::FN_PUSH;
      end else if (pick < 55) begin
         op.func = swhb_pkg::FN_POP;
      end else if (pick < 85) begin
         off = $urandom_range(1, fill);
         len = $urandom_range(1, off < MAX_COPY ? off : MAX_COPY);
         op.func = swhb_pkg::FN_COPY;
         op.copy_offset = swhb_pkg::OFF_W'(off);
         op.copy_length = swhb_pkg::LEN_W'(len);
      end else if (pick < 93) begin
         op.func = swhb_pkg::FN_COPY;
         case ($urandom_range(0, 3))
            0: op.copy_length = '0;
            1: op.copy_length = swhb_pkg::LEN_W'($urandom_range(MAX_COPY + 1, 127));
            2: begin
               off = $urandom_range(1, MAX_COPY - 1);
               op.copy_offset = swhb_pkg::OFF_W'(off);
               op.copy_length = swhb_pkg::LEN_W'($urandom_range(off + 1, MAX_COPY));
            end
            default: begin
               if (fill < 32767) begin
                  op.copy_offset = swhb_pkg::OFF_W'($urandom_range(fill + 1, 32767));
                  op.copy_length = swhb_pkg::LEN_W'($urandom_range(1, MAX_COPY));
               end else begin
                  op.copy_length = '0;
               end
            end
         endcase
      end else if (pick < 96) begin
         op.func = swhb_pkg::FN_CLEAR;
      end else begin
         op.func = swhb_pkg::func_type'($urandom_range(0, 3));
      end
      return op;
   endfunction

   task automatic send_op(input swhb_pkg::req_type op, input bit typed,
                          input swhb_pkg::rsp_type beat);
      int unsigned gap;
      gap = 0;
      if (!sender_quiet && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 12);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= op;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      predict_window_op(op);
      if (typed) begin
         pending_beats.push_back(beat);
      end else begin
         foreach (op_beats[i]) pending_beats.push_back(op_beats[i]);
      end
   endtask

   function automatic void check_beat(input swhb_pkg::rsp_type got);
      swhb_pkg::rsp_type want;
      if (pending_beats.size() == 0) begin
         $display("%0t: beat with none expected, actual %h", $time, got);
         mismatch_count++;
         return;
      end
      want = pending_beats.pop_front();
      if (got.data_out !== want.data_out) begin
         $display("%0t: data_out expected %0h actual %0h", $time, want.data_out, got.data_out);
         mismatch_count++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
         mismatch_count++;
      end
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         mismatch_count++;
      end
      if (got.fill_count !== want.fill_count) begin
         $display("%0t: fill_count expected %0d actual %0d", $time, want.fill_count,
                  got.fill_count);
         mismatch_count++;
      end
      if (got.is_empty !== want.is_empty) begin
         $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty,
                  got.is_empty);
         mismatch_count++;
      end
   endfunction

   // The receiver stalls once for a long stretch so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_beat(rsp_data);
         rx_cycles++;
         if (rx_cycles == 600) rx_hold = 300;
         if (rx_hold != 0) begin
            rx_hold--;
            rsp_pop <= 1'b0;
         end else if (rx_cycles > 1200 && rx_cycles < 2200) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= 8);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      add_row(mk_req(swhb_pkg::FN_POP, 8'hFF, 0, 0), 1'b1,
              mk_beat(0, swhb_pkg::ST_POP_EMPTY, 0));
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 1, 1), 1'b1,
              mk_beat(0, swhb_pkg::ST_COPY_BAD, 0));
      add_row(mk_req(swhb_pkg::FN_PUSH, 8'h00, 0, 0), 1'b1, mk_beat(0, swhb_pkg::ST_OK, 1));
      add_row(mk_req(swhb_pkg::FN_PUSH, 8'hFF, 0, 0), 1'b1, mk_beat(0, swhb_pkg::ST_OK, 2));
      add_row(mk_req(swhb_pkg::FN_PUSH, 8'hA5, 0, 0), 1'b1, mk_beat(0, swhb_pkg::ST_OK, 3));
      add_row(mk_req(swhb_pkg::FN_PUSH, 8'h5A, 0, 0), 1'b1, mk_beat(0, swhb_pkg::ST_OK, 4));
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 0, 1), 1'b1,
              mk_beat(0, swhb_pkg::ST_COPY_BAD, 4));
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 65, 70), 1'b1,
              mk_beat(0, swhb_pkg::ST_COPY_BAD, 4));
      add_row(mk_req(swhb_pkg::FN_COPY, 8'hFF, 127, 32767), 1'b1,
              mk_beat(0, swhb_pkg::ST_COPY_BAD, 4));
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 3, 2), 1'b1,
              mk_beat(0, swhb_pkg::ST_COPY_BAD, 4));
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 2, 5), 1'b1,
              mk_beat(0, swhb_pkg::ST_COPY_BAD, 4));
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 4, 4), 1'b0, '0);
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 1, 1), 1'b0, '0);
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 2, 3), 1'b0, '0);
      add_row(mk_req(swhb_pkg::FN_POP, 0, 0, 0), 1'b1, mk_beat(8'h00, swhb_pkg::ST_OK, 3));
      add_row(mk_req(swhb_pkg::FN_POP, 0, 0, 0), 1'b1, mk_beat(8'hFF, swhb_pkg::ST_OK, 2));
      add_row(mk_req(swhb_pkg::FN_CLEAR, 0, 0, 0), 1'b1, mk_beat(0, swhb_pkg::ST_OK, 0));
      add_row(mk_req(swhb_pkg::FN_POP, 0, 0, 0), 1'b1,
              mk_beat(0, swhb_pkg::ST_POP_EMPTY, 0));
      add_row(mk_req(swhb_pkg::FN_PUSH, 8'h81, 0, 0), 1'b1, mk_beat(0, swhb_pkg::ST_OK, 1));
      add_row(mk_req(swhb_pkg::FN_COPY, 0, 1, 1), 1'b1, mk_beat(8'h81, swhb_pkg::ST_OK, 1));
      add_row(mk_req(swhb_pkg::FN_PUSH, 8'h7E, 127, 32767), 1'b1,
              mk_beat(0, swhb_pkg::ST_OK, 2));
      add_row(mk_req(swhb_pkg::FN_CLEAR, 8'hFF, 127, 32767), 1'b1,
              mk_beat(0, swhb_pkg::ST_OK, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i])
         send_op(directed_steps[i].op, directed_steps[i].typed, directed_steps[i].beat);

      for (int i = 0; i < RANDOM_OPS; i++) begin
         sender_quiet = (i >= 150 && i < 300);
         send_op(random_window_op(), 1'b0, '0);
      end
      sender_quiet = 1'b0;

      // Copy from the farthest reach back before emptying the window again.
      send_op(mk_req(swhb_pkg::FN_PUSH, $urandom_range(0, 255), 0, 0), 1'b0, '0);
      send_op(mk_req(swhb_pkg::FN_COPY, 0,
                     (window_fill() < MAX_COPY) ? window_fill() : MAX_COPY,
                     window_fill()), 1'b0, '0);
      send_op(mk_req(swhb_pkg::FN_COPY, 0, 1, window_fill()), 1'b0, '0);
      repeat (4) send_op(mk_req(swhb_pkg::FN_POP, 0, 0, 0), 1'b0, '0);
      send_op(mk_req(swhb_pkg::FN_CLEAR, 0, 0, 0), 1'b0, '0);
      send_op(mk_req(swhb_pkg::FN_POP, 0, 0, 0), 1'b0, '0);

      req_push <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
